// ----- hdl/gcd_pkg.sv -----
// Shared types, constants and tables for the great-circle distance pipeline.
// Used by every module under hdl/; depends on nothing.
package gcd_pkg;

  localparam int CORDIC_STEPS = 32;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam int ANG_W     = 32;  // angle magnitude, 5e-8 degree
  localparam int U_W       = 31;  // folded angle, at most a quarter turn
  localparam int DIV_CELLS = 2;   // remainder corrections after the reciprocal estimate
  localparam int DREM_W    = 34;
  localparam int SQ_STEPS  = 64;
  localparam int SQ_STEP_W = 6;
  localparam int ROOT_W    = 61;
  localparam int REM_W     = 66;
  localparam int DIST_W    = 35;

  localparam int QM_LAT   = 5;
  localparam int SC_LAT   = 7 + DIV_CELLS + CORDIC_STEPS;
  localparam int PIPE_LAT = 1 + SC_LAT + 2 * QM_LAT + 2 + SQ_STEPS + CORDIC_STEPS + 1 + QM_LAT;

  localparam logic [63:0] PI_Q60    = 64'h3243F6A8885A308D;
  localparam logic [63:0] GAIN_Q60  = 64'd700114967507363210;
  localparam logic [63:0] ONE_Q60   = 64'd1 << 60;
  localparam logic [63:0] RADIUS_MM = 64'd6371000000;

  localparam logic [ANG_W-1:0] HALF_TURN    = 32'd3600000000;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'd1800000000;

  // PI_Q60 = RAD_K * HALF_TURN + RAD_R, so u*PI/D = u*K + (u*R)/D
  localparam logic [63:0] RAD_K64 = PI_Q60 / 64'd3600000000;
  localparam logic [63:0] RAD_R64 = PI_Q60 % 64'd3600000000;
  localparam logic [29:0] RAD_K   = RAD_K64[29:0];
  localparam logic [31:0] RAD_R   = RAD_R64[31:0];

  // floor(2^63 / HALF_TURN); the quotient estimate is low by at most two
  localparam logic [63:0] RECIP64 = (64'd1 << 63) / 64'd3600000000;
  localparam logic [31:0] RECIP   = RECIP64[31:0];

  typedef logic signed [63:0]            q60_t;
  typedef logic [STEP_W-1:0]             cstep_t;
  typedef logic [SQ_STEP_W-1:0]          sqstep_t;
  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_t;

  typedef struct packed {
    q60_t x;
    q60_t y;
    q60_t z;
  } cordic_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W-1:0] v;
  } sq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [U_W-1:0]    quo;
  } div_t;

  // atan(2^-i) in Q60 from the Q62 series, rounded
  function automatic atan_tab_t atan_build();
    atan_tab_t   t;
    logic [63:0] sum;
    logic [63:0] term;
    t = '0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (i == 0) begin
        t[i] = (PI_Q60 + 64'd2) >> 2;
      end else begin
        sum = '0;
        for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
          term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
          if (k % 2 == 1) sum = sum - term;
          else sum = sum + term;
        end
        t[i] = (sum + 64'd2) >> 2;
      end
    end
    return t;
  endfunction

  localparam atan_tab_t ATAN_TAB = atan_build();

endpackage

// ----- hdl/gcd_div_cell.sv -----
// One remainder correction step by the half-turn constant (degrees to radians).
// Depends on gcd_pkg.
module gcd_div_cell (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::div_t d_i,
  output gcd_pkg::div_t d_o
);

  gcd_pkg::div_t d_r, d_nxt;
  logic          ge;

  always_comb begin
    ge        = d_i.rem >= gcd_pkg::DREM_W'(gcd_pkg::HALF_TURN);
    d_nxt.rem = ge ? d_i.rem - gcd_pkg::DREM_W'(gcd_pkg::HALF_TURN) : d_i.rem;
    d_nxt.quo = d_i.quo + gcd_pkg::U_W'(ge);
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_o = d_r;

endmodule

// ----- hdl/gcd_cordic_cell.sv -----
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// Depends on gcd_pkg (state struct, arctangent table).
module gcd_cordic_cell (
  input  logic             clk,
  input  logic             en,
  input  logic             vectoring_i,
  input  gcd_pkg::cstep_t  step_i,
  input  gcd_pkg::cordic_t c_i,
  output gcd_pkg::cordic_t c_o
);

  gcd_pkg::cordic_t c_r, c_nxt;
  gcd_pkg::q60_t    x, y, z, dx, dy, at;
  logic             up;

  always_comb begin
    x  = c_i.x;
    y  = c_i.y;
    z  = c_i.z;
    dx = y >>> step_i;
    dy = x >>> step_i;
    at = gcd_pkg::q60_t'(gcd_pkg::ATAN_TAB[step_i]);
    // up: x -= dx, y += dy, z -= atan
    up = vectoring_i ? y[63] : ~z[63];
    if (up) begin
      c_nxt.x = x - dx;
      c_nxt.y = y + dy;
      c_nxt.z = z - at;
    end else begin
      c_nxt.x = x + dx;
      c_nxt.y = y - dy;
      c_nxt.z = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) c_r <= c_nxt;
  end

  assign c_o = c_r;

endmodule

// ----- hdl/gcd_sqrt_cell.sv -----
// One digit step of a restoring integer square root of (v << 60), registered.
// Depends on gcd_pkg.
module gcd_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  gcd_pkg::sqstep_t step_i,
  input  gcd_pkg::sq_t     s_i,
  output gcd_pkg::sq_t     s_o
);

  gcd_pkg::sq_t             s_r, s_nxt;
  logic [67:0]              vpad;
  logic [5:0]               off;
  logic [1:0]               pair;
  logic [gcd_pkg::REM_W-1:0] cur, trial;
  logic                     ge;

  always_comb begin
    // low 60 bits of the radicand are zero
    vpad  = 68'(s_i.v);
    off   = step_i - 6'd30;
    pair  = (step_i >= 6'd30) ? 2'(vpad >> {off, 1'b0}) : 2'b00;
    cur   = {s_i.rem[gcd_pkg::REM_W-3:0], pair};
    trial = gcd_pkg::REM_W'({s_i.root, 2'b01});
    ge    = cur >= trial;
    s_nxt.rem  = ge ? cur - trial : cur;
    s_nxt.root = {s_i.root[gcd_pkg::ROOT_W-2:0], ge};
    s_nxt.v    = s_i.v;
  end

  always_ff @(posedge clk) begin
    if (en) s_r <= s_nxt;
  end

  assign s_o = s_r;

endmodule

// ----- hdl/gcd_qmul.sv -----
// Pipelined signed Q60 multiply, rounded on magnitude, from 32x32 partial products.
// Depends on gcd_pkg.
module gcd_qmul (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::q60_t a_i,
  input  gcd_pkg::q60_t b_i,
  output gcd_pkg::q60_t p_o
);

  logic [63:0]   ma_r, mb_r;
  logic [63:0]   p00_r, p01_r, p10_r, p11_r;
  logic [64:0]   mid_r, lo_r;
  logic [63:0]   hi_r;
  logic [63:0]   r_r;
  gcd_pkg::q60_t p_r;
  logic          neg_r [gcd_pkg::QM_LAT-1];
  logic [127:0]  sum;

  assign sum = {hi_r, 64'd0} + (128'(mid_r) << 32) + 128'(lo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      mb_r  <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      p00_r <= 64'(ma_r[31:0]) * 64'(mb_r[31:0]);
      p01_r <= 64'(ma_r[31:0]) * 64'(mb_r[63:32]);
      p10_r <= 64'(ma_r[63:32]) * 64'(mb_r[31:0]);
      p11_r <= 64'(ma_r[63:32]) * 64'(mb_r[63:32]);
      mid_r <= 65'(p01_r) + 65'(p10_r);
      lo_r  <= 65'(p00_r) + 65'(gcd_pkg::ONE_Q60 >> 1);
      hi_r  <= p11_r;
      r_r   <= sum[123:60];
      p_r   <= neg_r[gcd_pkg::QM_LAT-2] ? -gcd_pkg::q60_t'(r_r) : gcd_pkg::q60_t'(r_r);
      neg_r[0] <= a_i[63] ^ b_i[63];
      for (int k = 1; k < gcd_pkg::QM_LAT - 1; k++) neg_r[k] <= neg_r[k-1];
    end
  end

  assign p_o = p_r;

endmodule

// ----- hdl/gcd_sincos.sv -----
// Sine or cosine of an angle in 5e-8 degree: quadrant fold, conversion to Q60
// radians by reciprocal multiply and correction cells, then a row of CORDIC cells. Depends on gcd_pkg.
module gcd_sincos (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      want_cos_i,
  input  logic [gcd_pkg::ANG_W-1:0] w_i,
  output gcd_pkg::q60_t             val_o
);

  logic                          half, quart, flip;
  logic [gcd_pkg::ANG_W-1:0]     w_a, u_full;
  logic [gcd_pkg::U_W-1:0]       u_r;
  logic                          flip_r [gcd_pkg::SC_LAT-1];
  logic [62:0]                   num_r, n3_r, n4_r, pm_r, qd_r;
  logic [gcd_pkg::U_W-1:0]       qe_r;
  logic [60:0]                   uk_r [gcd_pkg::DIV_CELLS+4];
  gcd_pkg::div_t                 d0_r;
  gcd_pkg::div_t                 dv [gcd_pkg::DIV_CELLS+1];
  gcd_pkg::q60_t                 z_r;
  gcd_pkg::cordic_t              cc [gcd_pkg::CORDIC_STEPS+1];
  gcd_pkg::q60_t                 pick, val_r;

  always_comb begin
    half   = w_i >= gcd_pkg::HALF_TURN;
    w_a    = half ? w_i - gcd_pkg::HALF_TURN : w_i;
    quart  = w_a > gcd_pkg::QUARTER_TURN;
    u_full = quart ? gcd_pkg::HALF_TURN - w_a : w_a;
    flip   = want_cos_i ? (half ^ quart) : half;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r       <= u_full[gcd_pkg::U_W-1:0];
      flip_r[0] <= flip;
      for (int k = 1; k < gcd_pkg::SC_LAT - 1; k++) flip_r[k] <= flip_r[k-1];
      num_r     <= 63'(u_r) * 63'(gcd_pkg::RAD_R) + 63'(gcd_pkg::QUARTER_TURN);
      uk_r[0]   <= 61'(u_r) * 61'(gcd_pkg::RAD_K);
      for (int k = 1; k <= gcd_pkg::DIV_CELLS + 3; k++) uk_r[k] <= uk_r[k-1];
      // quotient estimate from the top 32 numerator bits, never above the true quotient
      pm_r      <= 63'(64'(num_r[62:31]) * 64'(gcd_pkg::RECIP));
      n3_r      <= num_r;
      qe_r      <= pm_r[62:32];
      qd_r      <= 63'(pm_r[62:32]) * 63'(gcd_pkg::HALF_TURN);
      n4_r      <= n3_r;
      d0_r.rem  <= gcd_pkg::DREM_W'(n4_r - qd_r);
      d0_r.quo  <= qe_r;
      z_r       <= 64'(uk_r[gcd_pkg::DIV_CELLS+3]) + 64'(dv[gcd_pkg::DIV_CELLS].quo);
      val_r     <= flip_r[gcd_pkg::SC_LAT-2] ? -pick : pick;
    end
  end

  assign dv[0] = d0_r;

  genvar g;
  for (g = 0; g < gcd_pkg::DIV_CELLS; g++) begin : g_div
    gcd_div_cell u_div (
      .clk (clk),
      .en  (en),
      .d_i (dv[g]),
      .d_o (dv[g+1])
    );
  end

  assign cc[0].x = gcd_pkg::q60_t'(gcd_pkg::GAIN_Q60);
  assign cc[0].y = '0;
  assign cc[0].z = z_r;

  for (g = 0; g < gcd_pkg::CORDIC_STEPS; g++) begin : g_rot
    gcd_cordic_cell u_rot (
      .clk         (clk),
      .en          (en),
      .vectoring_i (1'b0),
      .step_i      (gcd_pkg::cstep_t'(g)),
      .c_i         (cc[g]),
      .c_o         (cc[g+1])
    );
  end

  assign pick  = want_cos_i ? cc[gcd_pkg::CORDIC_STEPS].x : cc[gcd_pkg::CORDIC_STEPS].y;
  assign val_o = val_r;

endmodule

// ----- hdl/great_circle_distance.sv -----
// Haversine great-circle distance, top level: pipeline, output skid and checks.
// Depends on gcd_pkg, gcd_sincos, gcd_qmul, gcd_sqrt_cell, gcd_cordic_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries two positions (latitude and
//   longitude in signed 1e-7 degree). Output channel out_valid/out_ready
//   returns one distance_mm per item, in order, on a 6371 km sphere.
//   The block is one pipeline of registered cells: four sine/cosine rows
//   (fold, reciprocal multiply with 2 correction cells, 32 CORDIC cells),
//   Q60 multipliers, two rows of 64 square-root cells and a row of 32
//   vectoring CORDIC cells.
//   From acceptance an item passes 156 pipeline stages and then the output
//   register before out_valid.
//   Throughput: one item per cycle while the skid is empty and the pipeline advances.
//   A result waiting at the output register does not stop intake; a second
//   held result goes into a one-entry skid, and only while that skid is full
//   does in_ready drop and the whole pipeline hold.
//   Reset (rst_n low, synchronous) empties the pipeline, output and skid;
//   no item is in flight afterward and no clearing pass is needed.
module great_circle_distance (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [30:0]          in_first_latitude,
  input  logic signed [31:0]          in_first_longitude,
  input  logic signed [30:0]          in_second_latitude,
  input  logic signed [31:0]          in_second_longitude,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gcd_pkg::DIST_W-1:0]  out_distance_mm
);

  logic                       adv, pipe_v, push, take;
  logic                       vld_r [gcd_pkg::PIPE_LAT];
  logic signed [31:0]         dlat;
  logic signed [32:0]         dlon;
  logic [30:0]                alat1, alat2;
  logic [gcd_pkg::ANG_W-1:0]  w_nxt [4];
  logic [gcd_pkg::ANG_W-1:0]  w_r [4];
  gcd_pkg::q60_t              trig [4];
  gcd_pkg::q60_t              sq_s1, sq_s2, c12, hav_b;
  gcd_pkg::q60_t              ss_r [gcd_pkg::QM_LAT];
  gcd_pkg::q60_t              sum_r, tt_r, dist_q;
  logic [gcd_pkg::ROOT_W-1:0] a_r, b_r;
  logic [63:0]                a_c;
  gcd_pkg::sq_t               sy [gcd_pkg::SQ_STEPS+1];
  gcd_pkg::sq_t               sx [gcd_pkg::SQ_STEPS+1];
  gcd_pkg::cordic_t           vc [gcd_pkg::CORDIC_STEPS+1];
  gcd_pkg::q60_t              z_fin;
  logic [gcd_pkg::DIST_W-1:0] pipe_d;
  logic                       out_v_r, skid_v_r;
  logic [gcd_pkg::DIST_W-1:0] out_d_r, skid_d_r;

  assign adv      = !skid_v_r;
  assign in_ready = adv;

  // angle magnitudes in 5e-8 degree
  always_comb begin
    dlat     = 32'(in_second_latitude) - 32'(in_first_latitude);
    dlon     = 33'(in_second_longitude) - 33'(in_first_longitude);
    alat1    = in_first_latitude[30] ? 31'(-in_first_latitude) : 31'(in_first_latitude);
    alat2    = in_second_latitude[30] ? 31'(-in_second_latitude) : 31'(in_second_latitude);
    w_nxt[0] = dlat[31] ? 32'(-dlat) : 32'(dlat);
    w_nxt[1] = dlon[32] ? 32'(-dlon) : 32'(dlon);
    w_nxt[2] = {alat1, 1'b0};
    w_nxt[3] = {alat2, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < gcd_pkg::PIPE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < gcd_pkg::PIPE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  assign pipe_v = vld_r[gcd_pkg::PIPE_LAT-1];

  genvar g;
  for (g = 0; g < 4; g++) begin : g_trig
    gcd_sincos u_sc (
      .clk        (clk),
      .en         (adv),
      .want_cos_i (g >= 2),
      .w_i        (w_r[g]),
      .val_o      (trig[g])
    );
  end

  gcd_qmul u_sq_lat (.clk(clk), .en(adv), .a_i(trig[0]), .b_i(trig[0]), .p_o(sq_s1));
  gcd_qmul u_sq_lon (.clk(clk), .en(adv), .a_i(trig[1]), .b_i(trig[1]), .p_o(sq_s2));
  gcd_qmul u_cc     (.clk(clk), .en(adv), .a_i(trig[2]), .b_i(trig[3]), .p_o(c12));
  gcd_qmul u_cross  (.clk(clk), .en(adv), .a_i(c12),     .b_i(sq_s2),   .p_o(hav_b));

  // clamp a to [0, 1]
  always_comb begin
    if (sum_r[63]) a_c = '0;
    else if (sum_r > gcd_pkg::q60_t'(gcd_pkg::ONE_Q60)) a_c = gcd_pkg::ONE_Q60;
    else a_c = sum_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) w_r[k] <= w_nxt[k];
      ss_r[0] <= sq_s1;
      for (int k = 1; k < gcd_pkg::QM_LAT; k++) ss_r[k] <= ss_r[k-1];
      sum_r <= ss_r[gcd_pkg::QM_LAT-1] + hav_b;
      a_r   <= a_c[gcd_pkg::ROOT_W-1:0];
      b_r   <= gcd_pkg::ROOT_W'(gcd_pkg::ONE_Q60 - a_c);
      tt_r  <= z_fin[63] ? '0 : (z_fin <<< 1);
    end
  end

  assign sy[0] = '{rem: '0, root: '0, v: a_r};
  assign sx[0] = '{rem: '0, root: '0, v: b_r};

  for (g = 0; g < gcd_pkg::SQ_STEPS; g++) begin : g_sqrt
    gcd_sqrt_cell u_sqy (
      .clk    (clk),
      .en     (adv),
      .step_i (gcd_pkg::sqstep_t'(gcd_pkg::SQ_STEPS - 1 - g)),
      .s_i    (sy[g]),
      .s_o    (sy[g+1])
    );
    gcd_sqrt_cell u_sqx (
      .clk    (clk),
      .en     (adv),
      .step_i (gcd_pkg::sqstep_t'(gcd_pkg::SQ_STEPS - 1 - g)),
      .s_i    (sx[g]),
      .s_o    (sx[g+1])
    );
  end

  assign vc[0].x = gcd_pkg::q60_t'(64'(sx[gcd_pkg::SQ_STEPS].root));
  assign vc[0].y = gcd_pkg::q60_t'(64'(sy[gcd_pkg::SQ_STEPS].root));
  assign vc[0].z = '0;

  for (g = 0; g < gcd_pkg::CORDIC_STEPS; g++) begin : g_vec
    gcd_cordic_cell u_vec (
      .clk         (clk),
      .en          (adv),
      .vectoring_i (1'b1),
      .step_i      (gcd_pkg::cstep_t'(g)),
      .c_i         (vc[g]),
      .c_o         (vc[g+1])
    );
  end

  assign z_fin = vc[gcd_pkg::CORDIC_STEPS].z;

  gcd_qmul u_scale (
    .clk (clk),
    .en  (adv),
    .a_i (tt_r),
    .b_i (gcd_pkg::q60_t'(gcd_pkg::RADIUS_MM)),
    .p_o (dist_q)
  );

  assign pipe_d = dist_q[gcd_pkg::DIST_W-1:0];

  // output register plus one-entry skid
  assign take = out_ready || !out_v_r;
  assign push = adv && pipe_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_d_r <= skid_v_r ? skid_d_r : pipe_d;
    if (!take && push) skid_d_r <= pipe_d;
  end

  assign out_valid       = out_v_r;
  assign out_distance_mm = out_d_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds an item while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ready))
    else $error("skid filled without an output stall");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(skid_v_r) |-> $past(out_ready))
    else $error("skid drained without output acceptance");

endmodule

// ----- tb/tb_top.sv -----
// Testbench for great_circle_distance: directed table then random position pairs,
// every distance checked against a bit-exact haversine/CORDIC predictor.
// Depends on gcd_pkg and great_circle_distance.
`timescale 1ns / 1ps

module tb_top;

  localparam int N_RANDOM  = 1900;
  localparam int QUIET_TAIL = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct {
    logic signed [30:0] lat1;
    logic signed [31:0] lon1;
    logic signed [30:0] lat2;
    logic signed [31:0] lon2;
  } fix_pair_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [30:0]          in_first_latitude;
  logic signed [31:0]          in_first_longitude;
  logic signed [30:0]          in_second_latitude;
  logic signed [31:0]          in_second_longitude;
  logic                        out_valid;
  logic                        out_ready;
  logic [gcd_pkg::DIST_W-1:0]  out_distance_mm;

  logic [gcd_pkg::DIST_W-1:0] dist_expected_q[$];
  logic [63:0]                atan_rom[gcd_pkg::CORDIC_STEPS];
  int                         err_count;
  int                         cycle_count;
  bit                         quiet;

  great_circle_distance i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_first_latitude   (in_first_latitude),
    .in_first_longitude  (in_first_longitude),
    .in_second_latitude  (in_second_latitude),
    .in_second_longitude (in_second_longitude),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_distance_mm     (out_distance_mm)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic logic [63:0] atan_series(int i);
    logic [63:0] sum;
    logic [63:0] term;
    sum = '0;
    if (i == 0) return (gcd_pkg::PI_Q60 + 64'd2) >> 2;
    for (int k = 0; (2 * k + 1) * i <= 62; k++) begin
      term = (64'd1 << (62 - (2 * k + 1) * i)) / 64'(2 * k + 1);
      if (k % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return (sum + 64'd2) >> 2;
  endfunction

  function automatic longint turn_to_rad(logic [63:0] u);
    logic [127:0] p;
    p = {64'd0, u} * {64'd0, gcd_pkg::PI_Q60} + 128'd1800000000;
    p = p / 128'd3600000000;
    return longint'(p[63:0]);
  endfunction

  function automatic void sin_cos(input logic [63:0] w_in, output longint s, output longint c);
    logic [63:0] w;
    bit          sneg;
    bit          cneg;
    longint      x, y, z, dx, dy;
    w = w_in % 64'd7200000000;
    sneg = 0;
    cneg = 0;
    if (w >= 64'd3600000000) begin
      w = w - 64'd3600000000;
      sneg = 1;
      cneg = 1;
    end
    if (w > 64'd1800000000) begin
      w = 64'd3600000000 - w;
      cneg = !cneg;
    end
    z = turn_to_rad(w);
    x = longint'(gcd_pkg::GAIN_Q60);
    y = 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_rom[i]);
      end else begin
        x += dx; y -= dy; z += longint'(atan_rom[i]);
      end
    end
    s = sneg ? -y : y;
    c = cneg ? -x : x;
  endfunction

  function automatic longint mul_q60(longint a, longint b);
    logic [63:0]  ma, mb;
    logic [127:0] p;
    longint       r;
    ma = (a < 0) ? 64'(-a) : 64'(a);
    mb = (b < 0) ? 64'(-b) : 64'(b);
    p = {64'd0, ma} * {64'd0, mb} + (128'd1 << 59);
    r = longint'(p[123:60]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint isqrt_q60(logic [63:0] v);
    logic [127:0] src, rem, trial;
    logic [63:0]  root;
    src = {64'd0, v} << 60;
    rem = '0;
    root = '0;
    for (int p = 63; p >= 0; p--) begin
      rem = (rem << 2) | 128'(src[2 * p +: 2]);
      trial = (128'(root) << 2) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return longint'(root);
  endfunction

  function automatic logic [gcd_pkg::DIST_W-1:0] haversine_mm(fix_pair_t pr);
    longint       la1, lo1, la2, lo2, d;
    longint       s1, s2, c1, c2, unused, a, x, y, z, dx, dy;
    logic [63:0]  theta;
    logic [127:0] p;
    la1 = pr.lat1; lo1 = pr.lon1; la2 = pr.lat2; lo2 = pr.lon2;
    d = la2 - la1;
    sin_cos(64'(d < 0 ? -d : d), s1, unused);
    d = lo2 - lo1;
    sin_cos(64'(d < 0 ? -d : d), s2, unused);
    sin_cos(64'(2 * (la1 < 0 ? -la1 : la1)), unused, c1);
    sin_cos(64'(2 * (la2 < 0 ? -la2 : la2)), unused, c2);
    a = mul_q60(s1, s1) + mul_q60(mul_q60(c1, c2), mul_q60(s2, s2));
    if (a < 0) a = 0;
    if (a > longint'(gcd_pkg::ONE_Q60)) a = longint'(gcd_pkg::ONE_Q60);
    y = isqrt_q60(64'(a));
    x = isqrt_q60(gcd_pkg::ONE_Q60 - 64'(a));
    z = 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(atan_rom[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(atan_rom[i]);
      end
    end
    theta = (z < 0) ? 64'd0 : 64'(z);
    p = {64'd0, 64'(2 * theta)} * {64'd0, gcd_pkg::RADIUS_MM} + (128'd1 << 59);
    return p[60 +: gcd_pkg::DIST_W];
  endfunction

  // ---------------- checking ----------------
  task automatic report_mismatch(string what, logic [gcd_pkg::DIST_W-1:0] got,
                                 logic [gcd_pkg::DIST_W-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (dist_expected_q.size() == 0) begin
        report_mismatch("unexpected item", out_distance_mm, '0);
      end else begin
        if (out_distance_mm !== dist_expected_q[0])
          report_mismatch("distance_mm", out_distance_mm, dist_expected_q[0]);
        void'(dist_expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", dist_expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic fix_pair_t make_random();
    fix_pair_t pr;
    int        sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      pr.lat1 = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
      pr.lon1 = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
      pr.lat2 = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
      pr.lon2 = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
    end else if (sel < 8) begin
      // nearby points, short distances
      pr.lat1 = 31'(longint'($urandom_range(0, 1780000000)) - 890000000);
      pr.lon1 = 32'(longint'($urandom_range(0, 32'd3560000000)) - 1780000000);
      pr.lat2 = pr.lat1 + 31'(longint'($urandom_range(0, 200000)) - 100000);
      pr.lon2 = pr.lon1 + 32'(longint'($urandom_range(0, 200000)) - 100000);
    end else begin
      pr.lat1 = 31'($urandom);
      pr.lon1 = 32'($urandom);
      pr.lat2 = 31'($urandom);
      pr.lon2 = 32'($urandom);
    end
    return pr;
  endfunction

  task automatic send_pair(fix_pair_t pr, bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_first_latitude   <= pr.lat1;
    in_first_longitude  <= pr.lon1;
    in_second_latitude  <= pr.lat2;
    in_second_longitude <= pr.lon2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    dist_expected_q.push_back(haversine_mm(pr));
  endtask

  // result side stall bursts
  initial begin
    int len;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        len = $urandom_range(1, 11);
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin
    fix_pair_t table_rows[$];
    fix_pair_t pr;
    err_count = 0;
    cycle_count = 0;
    quiet = 0;
    for (int i = 0; i < gcd_pkg::CORDIC_STEPS; i++) atan_rom[i] = atan_series(i);
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_first_latitude = '0;
    in_first_longitude = '0;
    in_second_latitude = '0;
    in_second_longitude = '0;

    // directed rows: lat1, lon1, lat2, lon2
    table_rows.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd0});
    table_rows.push_back('{31'sd453210000, -32'sd1220000000, 31'sd453210000, -32'sd1220000000});
    table_rows.push_back('{31'sd900000000, 32'sd0, -31'sd900000000, 32'sd0});
    table_rows.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1800000000});
    table_rows.push_back('{31'sd0, -32'sd1800000000, 31'sd0, 32'sd1800000000});
    table_rows.push_back('{31'sd900000000, 32'sd1800000000, 31'sd900000000, -32'sd1800000000});
    table_rows.push_back('{-31'sd900000000, 32'sd0, -31'sd900000000, 32'sd900000000});
    table_rows.push_back('{31'sd0, 32'sd0, 31'sd1, 32'sd0});
    table_rows.push_back('{31'sd0, 32'sd0, 31'sd0, 32'sd1});
    table_rows.push_back('{31'sd0, 32'sd0, 31'sd0, -32'sd1});
    table_rows.push_back('{31'sd1000000000, 32'sd100, -31'sd1000000000, -32'sd100});
    table_rows.push_back('{31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF});
    table_rows.push_back('{31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000});
    table_rows.push_back('{31'h40000000, 32'h7FFFFFFF, 31'h40000000, 32'h80000000});
    table_rows.push_back('{31'h7FFFFFFF, 32'hFFFFFFFF, 31'h00000000, 32'h00000000});
    table_rows.push_back('{31'sd450000000, 32'sd0, 31'sd450000000, 32'sd1800000000});
    table_rows.push_back('{31'sd899999999, 32'sd0, 31'sd900000000, 32'sd1800000000});
    table_rows.push_back('{-31'sd337000000, 32'sd1511000000, 31'sd515000000, -32'sd1200});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_pair(table_rows[i], 1'b1);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - QUIET_TAIL) quiet = 1;
      pr = make_random();
      send_pair(pr, !quiet);
    end
    in_valid <= 1'b0;

    while (dist_expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && dist_expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
